// File: sv/stsum_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stsum_pkg
// Shared constants, types and helpers for the segment tree range sum unit.
// ----------------------------------------------------------------------------
package stsum_pkg;

    localparam int LEAF_COUNT = 1024;
    localparam int LEAF_BITS  = $clog2(LEAF_COUNT);
    localparam int NODE_COUNT = 2 * LEAF_COUNT;
    localparam int NODE_BITS  = LEAF_BITS + 1;
    localparam int PTR_BITS   = NODE_BITS + 1;

    localparam int IDX_W     = 10;
    localparam int VAL_W     = 64;
    localparam int IN_DATA_W = 96;

    localparam logic REQ_UPDATE = 1'b0;
    localparam logic REQ_QUERY  = 1'b1;

    typedef logic [NODE_BITS-1:0] node_t;
    typedef logic [PTR_BITS-1:0]  ptr_t;
    typedef logic [VAL_W-1:0]     val_t;

    typedef struct packed {
        logic  we;
        node_t waddr;
        val_t  wdata;
        node_t raddr;
    } mem_req_t;

    typedef struct packed {
        logic load;
        val_t data;
    } res_t;

    // leaf number (index modulo LEAF_COUNT) mapped onto its tree node
    function automatic node_t leaf_node(input logic [IDX_W-1:0] idx);
        node_t n;
        n = NODE_BITS'(idx) & NODE_BITS'(LEAF_COUNT - 1);
        return n | NODE_BITS'(LEAF_COUNT);
    endfunction

endpackage
`default_nettype wire

// File: sv/stsum_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stsum_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module stsum_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 2048
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// File: sv/stsum_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stsum_ctrl
// Tree walker: clearing pass, leaf update with ancestor rebuild, range query.
// ----------------------------------------------------------------------------
module stsum_ctrl import stsum_pkg::*; (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic                 in_kind,
    input  wire logic [IDX_W-1:0]     in_index,
    input  wire logic [VAL_W-1:0]     in_value,
    input  wire logic [IDX_W-1:0]     in_low,
    input  wire logic [IDX_W-1:0]     in_high,
    output mem_req_t                  mem,
    input  wire val_t                 rdata,
    input  wire logic                 out_free,
    output res_t                      res
);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_ULEAF = 3'd2;
    localparam logic [2:0] ST_UWALK = 3'd3;
    localparam logic [2:0] ST_QA    = 3'd4;
    localparam logic [2:0] ST_QB    = 3'd5;
    localparam logic [2:0] ST_QFIN  = 3'd6;

    logic [2:0] state_reg, state_next;
    node_t      node_reg, node_next;
    ptr_t       a_reg, a_next;
    ptr_t       b_reg, b_next;
    val_t       acc_reg, acc_next;
    val_t       val_reg, val_next;
    logic       pend_reg, pend_next;

    val_t  sum;
    node_t parent;
    node_t lo_node;
    node_t hi_node;
    ptr_t  a_inc;
    ptr_t  b_dec;
    ptr_t  b_new;

    assign sum      = acc_reg + (pend_reg ? rdata : '0);
    assign parent   = node_reg >> 1;
    assign lo_node  = leaf_node(in_low);
    assign hi_node  = leaf_node(in_high);
    assign a_inc    = PTR_BITS'(a_reg + 1'b1);
    assign b_dec    = PTR_BITS'(b_reg - 1'b1);
    assign b_new    = b_reg[0] ? b_dec : b_reg;
    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        node_next  = node_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        acc_next   = sum;
        val_next   = val_reg;
        pend_next  = 1'b0;
        mem.we     = 1'b0;
        mem.waddr  = node_reg;
        mem.wdata  = sum;
        mem.raddr  = node_reg ^ NODE_BITS'(1);
        res.load   = 1'b0;
        res.data   = acc_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem.we    = 1'b1;
                mem.wdata = '0;
                node_next = node_reg + 1'b1;
                if (node_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    acc_next = '0;
                    if (in_kind == REQ_UPDATE)
                    begin
                        node_next  = leaf_node(in_index);
                        val_next   = in_value;
                        state_next = ST_ULEAF;
                    end
                    else
                    begin
                        if (lo_node > hi_node)
                        begin
                            a_next = PTR_BITS'(hi_node);
                            b_next = PTR_BITS'(lo_node) + 1'b1;
                        end
                        else
                        begin
                            a_next = PTR_BITS'(lo_node);
                            b_next = PTR_BITS'(hi_node) + 1'b1;
                        end
                        state_next = ST_QA;
                    end
                end
            end
            ST_ULEAF:
            begin
                mem.we     = 1'b1;
                mem.wdata  = val_reg;
                pend_next  = 1'b1;
                acc_next   = val_reg;
                state_next = ST_UWALK;
            end
            ST_UWALK:
            begin
                mem.we    = 1'b1;
                mem.waddr = parent;
                mem.raddr = parent ^ NODE_BITS'(1);
                node_next = parent;
                if (parent == NODE_BITS'(1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    pend_next = 1'b1;
                end
            end
            ST_QA:
            begin
                mem.raddr = a_reg[NODE_BITS-1:0];
                if (a_reg < b_reg)
                begin
                    if (a_reg[0])
                    begin
                        pend_next = 1'b1;
                        a_next    = a_inc;
                    end
                    state_next = ST_QB;
                end
                else
                begin
                    state_next = ST_QFIN;
                end
            end
            ST_QB:
            begin
                mem.raddr  = b_dec[NODE_BITS-1:0];
                pend_next  = b_reg[0];
                a_next     = a_reg >> 1;
                b_next     = b_new >> 1;
                state_next = ST_QA;
            end
            ST_QFIN:
            begin
                if (out_free)
                begin
                    res.load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            node_reg  <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            node_reg  <= node_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
        val_reg <= val_next;
    end

endmodule
`default_nettype wire

// File: sv/segment_tree_range_sum_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// segment_tree_range_sum_unit
// Point-update, range-sum segment tree over LEAF_COUNT 64-bit leaves.
// Update: writes the leaf, then rebuilds its ancestors, one node written per level.
// Query: the result is loaded into the output register, and the next transfer is
// taken in the cycle after; a finished result waits in the output register.
// Reset: a clearing pass zeroes all NODE_COUNT node memory words, tready low.
// ----------------------------------------------------------------------------
module segment_tree_range_sum_unit import stsum_pkg::*; (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    // [9:0] leaf_index, [73:10] leaf_value, [83:74] range_low,
    // [93:84] range_high, [95:94] zero
    input  wire logic [IN_DATA_W-1:0] s_axis_tdata,
    // [0] req_type
    input  wire logic                 s_axis_tuser,
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // [63:0] range_sum
    output logic      [VAL_W-1:0]     m_axis_tdata
);

    mem_req_t mem;
    val_t     rdata;
    res_t     res;
    logic     out_free;
    logic     out_valid_reg, out_valid_next;
    val_t     out_data_reg, out_data_next;

    assign out_free = !out_valid_reg || m_axis_tready;

    stsum_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_kind  (s_axis_tuser),
        .in_index (s_axis_tdata[9:0]),
        .in_value (s_axis_tdata[73:10]),
        .in_low   (s_axis_tdata[83:74]),
        .in_high  (s_axis_tdata[93:84]),
        .mem      (mem),
        .rdata    (rdata),
        .out_free (out_free),
        .res      (res)
    );

    stsum_ram #(
        .WIDTH (VAL_W),
        .DEPTH (NODE_COUNT)
    ) u_nodes (
        .clk   (clk),
        .we    (mem.we),
        .waddr (mem.waddr),
        .wdata (mem.wdata),
        .raddr (mem.raddr),
        .rdata (rdata)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (res.load)
        begin
            out_valid_next = 1'b1;
            out_data_next  = res.data;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule
`default_nettype wire
